// File: rtl/vfpt_pkg.sv
// Types and constants shared by the vehicle footprint pose transform.
package vfpt_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_FRONT_EDGE   = 3'd0;
  localparam logic [2:0] REG_REAR_EDGE    = 3'd1;
  localparam logic [2:0] REG_LEFT_EDGE    = 3'd2;
  localparam logic [2:0] REG_RIGHT_EDGE   = 3'd3;
  localparam logic [2:0] REG_MARGIN_FRONT = 3'd4;
  localparam logic [2:0] REG_MARGIN_REAR  = 3'd5;
  localparam logic [2:0] REG_MARGIN_LEFT  = 3'd6;
  localparam logic [2:0] REG_MARGIN_RIGHT = 3'd7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Edge plus margin
  localparam int unsigned EdgeW = 17;
  // CORDIC datapath: 30 fraction bits, x/y and residual angle
  localparam int unsigned CordicFrac = 30;
  localparam int unsigned XyW        = 33;
  localparam int unsigned AngW       = 33;
  localparam int unsigned AtanLen    = 24;

  localparam logic signed [XyW-1:0]  X_INIT    = 33'sd652032874;
  localparam logic signed [AngW-1:0] HALF_TURN = 33'sh0_8000_0000;
  localparam logic signed [15:0]     QUARTER   = 16'sd16384;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TABLE [AtanLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] heading;
    logic               skip_margins;
  } pose_t;

  typedef struct packed {
    logic signed [31:0] front_left_x;
    logic signed [31:0] front_left_y;
    logic signed [31:0] front_right_x;
    logic signed [31:0] front_right_y;
    logic signed [31:0] rear_right_x;
    logic signed [31:0] rear_right_y;
    logic signed [31:0] rear_left_x;
    logic signed [31:0] rear_left_y;
  } corners_t;

  typedef struct packed {
    logic signed [15:0] front_edge;
    logic signed [15:0] rear_edge;
    logic signed [15:0] left_edge;
    logic signed [15:0] right_edge;
    logic signed [14:0] margin_front;
    logic signed [14:0] margin_rear;
    logic signed [14:0] margin_left;
    logic signed [14:0] margin_right;
  } cfg_t;

  // Payload that rides along the CORDIC stages
  typedef struct packed {
    logic signed [31:0]      pose_x;
    logic signed [31:0]      pose_y;
    logic                    flip;
    logic signed [EdgeW-1:0] front;
    logic signed [EdgeW-1:0] rear;
    logic signed [EdgeW-1:0] left;
    logic signed [EdgeW-1:0] right;
  } carry_t;

endpackage

// File: rtl/vehicle_footprint_pose_transform_core.sv
// Vehicle footprint corners placed at a pose: CORDIC rotation and translation pipeline.
//
//   channel | signals                                     | direction
//   in      | in_valid_i, in_ready_o, in_data_i           | pose word in
//   out     | out_valid_o, out_ready_i, out_data_o        | four-corner word out
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i/data_i | register write
//
// One word per cycle while the output is not stalled; the stages are the input stage,
// one stage per CORDIC step, rounding, multiply, sum and saturate/output.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// close up and a word is taken while a result waits at the output, if a stage is empty.
// Reset clears the valid bits and the configuration registers.
module vehicle_footprint_pose_transform_core #(
  parameter int unsigned CORDIC_STEPS  = 16,
  parameter int unsigned FRACTION_BITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  vfpt_pkg::pose_t                 in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output vfpt_pkg::corners_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vfpt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [vfpt_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned N     = CORDIC_STEPS;
  localparam int unsigned NST   = N + 5;
  localparam int unsigned S_RND = N + 1;
  localparam int unsigned S_MUL = N + 2;
  localparam int unsigned S_SUM = N + 3;
  localparam int unsigned S_OUT = N + 4;

  localparam int unsigned XW  = vfpt_pkg::XyW;
  localparam int unsigned ZW  = vfpt_pkg::AngW;
  localparam int unsigned EW  = vfpt_pkg::EdgeW;
  localparam int unsigned SH  = vfpt_pkg::CordicFrac - FRACTION_BITS;
  localparam int unsigned CW  = XW + 1 - SH;
  localparam int unsigned PW  = EW + CW;
  localparam int unsigned SMW = PW + 2;
  localparam int unsigned RW  = SMW - FRACTION_BITS;
  localparam int unsigned OW  = 33;

  localparam logic signed [XW-1:0]  HALF_R = XW'(64'd1 << (SH - 1));
  localparam logic signed [SMW-1:0] HALF_F = SMW'(64'd1 << (FRACTION_BITS - 1));
  localparam logic signed [CW-1:0]  C_MAX  = CW'((64'd1 << FRACTION_BITS) + 64'd2);
  localparam logic signed [OW-1:0]  SAT_HI = 33'sh0_7FFF_FFFF;
  localparam logic signed [OW-1:0]  SAT_LO = -33'sh0_8000_0000;

  // ---------------- configuration ----------------
  vfpt_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vfpt_pkg::REG_FRONT_EDGE:   cfg_q.front_edge   <= cfg_data_i;
        vfpt_pkg::REG_REAR_EDGE:    cfg_q.rear_edge    <= cfg_data_i;
        vfpt_pkg::REG_LEFT_EDGE:    cfg_q.left_edge    <= cfg_data_i;
        vfpt_pkg::REG_RIGHT_EDGE:   cfg_q.right_edge   <= cfg_data_i;
        vfpt_pkg::REG_MARGIN_FRONT: cfg_q.margin_front <= cfg_data_i[14:0];
        vfpt_pkg::REG_MARGIN_REAR:  cfg_q.margin_rear  <= cfg_data_i[14:0];
        vfpt_pkg::REG_MARGIN_LEFT:  cfg_q.margin_left  <= cfg_data_i[14:0];
        vfpt_pkg::REG_MARGIN_RIGHT: cfg_q.margin_right <= cfg_data_i[14:0];
      endcase
    end
  end

  // ---------------- stage control ----------------
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[S_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------- input stage: angle fold and rectangle ----------------
  logic signed [ZW-1:0] ang_raw;
  logic                 flip_d;
  logic signed [ZW-1:0] z0_d;
  logic signed [EW-1:0] mf, mr, ml, mrt;
  vfpt_pkg::carry_t     cr0_d;

  always_comb begin
    ang_raw = {in_data_i.heading[15], in_data_i.heading, 16'b0};
    flip_d  = (in_data_i.heading > vfpt_pkg::QUARTER) ||
              (in_data_i.heading < -vfpt_pkg::QUARTER);
    if (!flip_d) begin
      z0_d = ang_raw;
    end else if (in_data_i.heading[15]) begin
      z0_d = ang_raw + vfpt_pkg::HALF_TURN;
    end else begin
      z0_d = ang_raw - vfpt_pkg::HALF_TURN;
    end
    mf  = in_data_i.skip_margins ? '0 : EW'(cfg_q.margin_front);
    mr  = in_data_i.skip_margins ? '0 : EW'(cfg_q.margin_rear);
    ml  = in_data_i.skip_margins ? '0 : EW'(cfg_q.margin_left);
    mrt = in_data_i.skip_margins ? '0 : EW'(cfg_q.margin_right);
    cr0_d.pose_x = in_data_i.pose_x;
    cr0_d.pose_y = in_data_i.pose_y;
    cr0_d.flip   = flip_d;
    cr0_d.front  = EW'(cfg_q.front_edge) + mf;
    cr0_d.rear   = EW'(cfg_q.rear_edge) - mr;
    cr0_d.left   = EW'(cfg_q.left_edge) + ml;
    cr0_d.right  = EW'(cfg_q.right_edge) - mrt;
  end

  logic signed [XW-1:0] x_w [N+1];
  logic signed [XW-1:0] y_w [N+1];
  logic signed [ZW-1:0] z_w [N];
  vfpt_pkg::carry_t     cr_q [N+1];
  logic signed [ZW-1:0] z0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      z0_q     <= z0_d;
      cr_q[0]  <= cr0_d;
    end
  end

  assign x_w[0] = vfpt_pkg::X_INIT;
  assign y_w[0] = '0;
  assign z_w[0] = z0_q;

  // ---------------- CORDIC stages, one step each ----------------
  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [XW-1:0] x_q, y_q;
    logic                 dir;

    assign dir = !z_w[i][ZW-1];

    always_ff @(posedge clk_i) begin
      if (en[i+1]) begin
        x_q       <= dir ? x_w[i] - (y_w[i] >>> i) : x_w[i] + (y_w[i] >>> i);
        y_q       <= dir ? y_w[i] + (x_w[i] >>> i) : y_w[i] - (x_w[i] >>> i);
        cr_q[i+1] <= cr_q[i];
      end
    end

    assign x_w[i+1] = x_q;
    assign y_w[i+1] = y_q;

    // The last step leaves no residual angle to track
    if (i < N - 1) begin : g_ang
      logic signed [ZW-1:0] z_q;
      logic signed [ZW-1:0] at;

      assign at = ZW'({1'b0, vfpt_pkg::ATAN_TABLE[i]});

      always_ff @(posedge clk_i) begin
        if (en[i+1]) begin
          z_q <= dir ? z_w[i] - at : z_w[i] + at;
        end
      end

      assign z_w[i+1] = z_q;
    end
  end

  // ---------------- round to cos/sin ----------------
  logic signed [XW-1:0] xr_sh, yr_sh;
  logic signed [CW-1:0] c_q, s_q;
  vfpt_pkg::carry_t     rnd_cr_q;

  assign xr_sh = (x_w[N] + HALF_R) >>> SH;
  assign yr_sh = (y_w[N] + HALF_R) >>> SH;

  always_ff @(posedge clk_i) begin
    if (en[S_RND]) begin
      c_q      <= cr_q[N].flip ? -CW'(xr_sh) : CW'(xr_sh);
      s_q      <= cr_q[N].flip ? -CW'(yr_sh) : CW'(yr_sh);
      rnd_cr_q <= cr_q[N];
    end
  end

  // ---------------- products ----------------
  // 0 fc, 1 fs, 2 rc, 3 rs, 4 lc, 5 ls, 6 rtc, 7 rts
  logic signed [PW-1:0] p_q [8];
  logic signed [31:0]   mul_px_q, mul_py_q;

  always_ff @(posedge clk_i) begin
    if (en[S_MUL]) begin
      p_q[0]   <= PW'(rnd_cr_q.front) * PW'(c_q);
      p_q[1]   <= PW'(rnd_cr_q.front) * PW'(s_q);
      p_q[2]   <= PW'(rnd_cr_q.rear)  * PW'(c_q);
      p_q[3]   <= PW'(rnd_cr_q.rear)  * PW'(s_q);
      p_q[4]   <= PW'(rnd_cr_q.left)  * PW'(c_q);
      p_q[5]   <= PW'(rnd_cr_q.left)  * PW'(s_q);
      p_q[6]   <= PW'(rnd_cr_q.right) * PW'(c_q);
      p_q[7]   <= PW'(rnd_cr_q.right) * PW'(s_q);
      mul_px_q <= rnd_cr_q.pose_x;
      mul_py_q <= rnd_cr_q.pose_y;
    end
  end

  // ---------------- rotate: u*c - v*s, u*s + v*c, rounded ----------------
  function automatic logic signed [RW-1:0] rnd_diff(logic signed [PW-1:0] a,
                                                     logic signed [PW-1:0] b);
    logic signed [SMW-1:0] t;
    t = SMW'(a) - SMW'(b) + HALF_F;
    return RW'(t >>> FRACTION_BITS);
  endfunction

  function automatic logic signed [RW-1:0] rnd_sum(logic signed [PW-1:0] a,
                                                    logic signed [PW-1:0] b);
    logic signed [SMW-1:0] t;
    t = SMW'(a) + SMW'(b) + HALF_F;
    return RW'(t >>> FRACTION_BITS);
  endfunction

  // 0..7: FL x/y, FR x/y, RR x/y, RL x/y
  logic signed [RW-1:0] r_q [8];
  logic signed [31:0]   sum_px_q, sum_py_q;

  always_ff @(posedge clk_i) begin
    if (en[S_SUM]) begin
      r_q[0]   <= rnd_diff(p_q[0], p_q[5]);
      r_q[1]   <= rnd_sum (p_q[1], p_q[4]);
      r_q[2]   <= rnd_diff(p_q[0], p_q[7]);
      r_q[3]   <= rnd_sum (p_q[1], p_q[6]);
      r_q[4]   <= rnd_diff(p_q[2], p_q[7]);
      r_q[5]   <= rnd_sum (p_q[3], p_q[6]);
      r_q[6]   <= rnd_diff(p_q[2], p_q[5]);
      r_q[7]   <= rnd_sum (p_q[3], p_q[4]);
      sum_px_q <= mul_px_q;
      sum_py_q <= mul_py_q;
    end
  end

  // ---------------- translate and saturate ----------------
  function automatic logic signed [31:0] place_sat(logic signed [31:0] p,
                                                   logic signed [RW-1:0] r);
    logic signed [OW-1:0] t;
    t = OW'(p) + OW'(r);
    if (t > SAT_HI) begin
      return SAT_HI[31:0];
    end else if (t < SAT_LO) begin
      return SAT_LO[31:0];
    end
    return t[31:0];
  endfunction

  vfpt_pkg::corners_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[S_OUT]) begin
      out_q.front_left_x  <= place_sat(sum_px_q, r_q[0]);
      out_q.front_left_y  <= place_sat(sum_py_q, r_q[1]);
      out_q.front_right_x <= place_sat(sum_px_q, r_q[2]);
      out_q.front_right_y <= place_sat(sum_py_q, r_q[3]);
      out_q.rear_right_x  <= place_sat(sum_px_q, r_q[4]);
      out_q.rear_right_y  <= place_sat(sum_py_q, r_q[5]);
      out_q.rear_left_x   <= place_sat(sum_px_q, r_q[6]);
      out_q.rear_left_y   <= place_sat(sum_py_q, r_q[7]);
    end
  end

  assign out_data_o = out_q;

  // ---------------- assertions ----------------
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted word did not enter the input stage");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q == '0 |-> in_ready_o)
    else $error("empty pipeline refuses input");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S_OUT] && !out_ready_i |=> v_q[S_OUT] && $stable(out_q))
    else $error("stalled result lost or changed");

  a_trig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S_RND] |-> (c_q <= C_MAX) && (c_q >= -C_MAX) &&
                   (s_q <= C_MAX) && (s_q >= -C_MAX))
    else $error("cos/sin out of unit range");

endmodule
